### rtl/doppler_aided_range_smoother_core_assert.svh
// Assertion macros for the range smoother core.
// Define NO_ASSERTIONS to compile them out.
`ifndef DOPPLER_AIDED_RANGE_SMOOTHER_CORE_ASSERT_SVH
`define DOPPLER_AIDED_RANGE_SMOOTHER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DARS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define DARS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");
`else
`define DARS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DARS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dars_pkg.sv
`timescale 1ns / 1ps
package dars_pkg;
	localparam int NUM_SATS   = 128;
	localparam int NUM_SLOTS  = 8;
	localparam int LOCK_BITS  = 16;
	localparam int SLOT_COUNT = NUM_SATS * NUM_SLOTS;
	localparam int SLOT_AW    = $clog2(SLOT_COUNT);

	localparam int SAT_W      = 7;
	localparam int FS_W       = 3;
	localparam int RANGE_W    = 36;
	localparam int DOP_W      = 26;
	localparam int LAM_W      = 32;
	localparam int TAG_W      = 16;
	localparam int OUT_LOCK_W = 16;

	localparam int WIN_W      = 10;
	localparam int INT_W      = 16;
	localparam int THR_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP     = 2'd2;
	localparam logic [WIN_W-1:0] WIN_RESET = 10'd100;
	localparam logic [INT_W-1:0] INT_RESET = 16'd256;
	localparam logic [THR_W-1:0] THR_RESET = 24'd10240;

	// Datapath widths of the smoothing arithmetic.
	localparam int TL_W    = INT_W + LAM_W;      // interval times wavelength
	localparam int HALF_W  = TL_W / 2;
	localparam int B_W     = DOP_W + 1;          // Doppler sum magnitude
	localparam int PP_W    = HALF_W + B_W;       // partial product
	localparam int MAG_W   = 37;
	localparam int BASE_W  = 39;
	localparam int PRODN_W = BASE_W + WIN_W + 1;
	localparam int NUM_W   = PRODN_W + 1;
	localparam int DVD_W   = NUM_W + 1;
	localparam int CNT_W   = $clog2(DVD_W);
	localparam int REM_W   = WIN_W + 1;
	localparam int QS_W    = DVD_W + 1;
	localparam int DIFF_W  = QS_W + 1;

	typedef struct packed {
		logic                 valid;
		logic [TAG_W-1:0]     tag;
		logic [LOCK_BITS-1:0] lock;
		logic [DOP_W-1:0]     dop;
		logic [RANGE_W-1:0]   rng;
	} slot_word_t;

	localparam int SLOT_W = $bits(slot_word_t);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_MUL_LO, ST_MUL_HI, ST_MAG, ST_BASE,
		ST_PROD, ST_NUM, ST_DIV_LOAD, ST_DIV, ST_SIGN, ST_CHECK, ST_WRITE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic read;
		logic eval;
		logic mul_lo;
		logic mul_hi;
		logic mag;
		logic base;
		logic prod;
		logic num;
		logic div_load;
		logic div_step;
		logic sign;
		logic check;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic smooth;
		logic div_done;
	} sts_t;
endpackage

### rtl/dars_ram.sv
`timescale 1ns / 1ps
module dars_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/dars_ctrl.sv
`timescale 1ns / 1ps
module dars_ctrl import dars_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:     if (start) state_d = ST_READ;
			ST_READ:     state_d = ST_EVAL;
			ST_EVAL:     state_d = sts.smooth ? ST_MUL_LO : ST_WRITE;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_MAG;
			ST_MAG:      state_d = ST_BASE;
			ST_BASE:     state_d = ST_PROD;
			ST_PROD:     state_d = ST_NUM;
			ST_NUM:      state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV:      if (sts.div_done) state_d = ST_SIGN;
			ST_SIGN:     state_d = ST_CHECK;
			ST_CHECK:    state_d = ST_WRITE;
			ST_WRITE:    state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR:    cmd.clear = 1'b1;
			ST_IDLE:     cmd.accept = start;
			ST_READ:     cmd.read = 1'b1;
			ST_EVAL:     cmd.eval = 1'b1;
			ST_MUL_LO:   cmd.mul_lo = 1'b1;
			ST_MUL_HI:   cmd.mul_hi = 1'b1;
			ST_MAG:      cmd.mag = 1'b1;
			ST_BASE:     cmd.base = 1'b1;
			ST_PROD:     cmd.prod = 1'b1;
			ST_NUM:      cmd.num = 1'b1;
			ST_DIV_LOAD: cmd.div_load = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_SIGN:     cmd.sign = 1'b1;
			ST_CHECK:    cmd.check = 1'b1;
			ST_WRITE:    cmd.write = 1'b1;
			default:     cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

### rtl/dars_dp.sv
`timescale 1ns / 1ps
module dars_dp import dars_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic                   epoch_start,
	input  logic [SAT_W-1:0]       sat_index,
	input  logic [FS_W-1:0]        freq_slot,
	input  logic [RANGE_W-1:0]     pseudorange,
	input  logic signed [DOP_W-1:0] doppler,
	input  logic [LAM_W-1:0]       wavelength,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   ram_we,
	output logic [SLOT_AW-1:0]     ram_waddr,
	output logic [SLOT_W-1:0]      ram_wdata,
	output logic                   ram_re,
	output logic [SLOT_AW-1:0]     ram_raddr,
	input  logic [SLOT_W-1:0]      ram_rdata,
	output logic [RANGE_W-1:0]     range_out,
	output logic [OUT_LOCK_W-1:0]  lock_count,
	output logic                   was_smoothed,
	output logic                   done
);
	logic [WIN_W-1:0] window_q;
	logic [INT_W-1:0] interval_q;
	logic [THR_W-1:0] thr_q;
	logic [TAG_W-1:0] epoch_q;
	logic             prev_ne_q, cur_ne_q;
	logic [SLOT_AW-1:0] clr_q;

	logic [RANGE_W-1:0] p_q;
	logic [DOP_W-1:0]   draw_q;
	logic [LAM_W-1:0]   lam_q;
	logic [SLOT_AW-1:0] idx_q;
	logic               inr_q;

	logic [TL_W-1:0]      tl_q;
	logic [LOCK_BITS-1:0] lock_q;
	logic [WIN_W-1:0]     n_q;
	logic [B_W-1:0]       b_q;
	logic                 neg_q;
	logic [RANGE_W-1:0]   prev_rng_q;
	logic [PP_W-1:0]      plo_q, phi_q;
	logic [MAG_W-1:0]     mag_q;
	logic signed [BASE_W-1:0]  base_q;
	logic signed [PRODN_W-1:0] prodn_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 sign_q;
	logic signed [QS_W-1:0] s_q;
	logic [RANGE_W-1:0]   res_rng_q;
	logic                 res_sm_q;

	slot_word_t           rd, wr;
	logic                 present;
	logic [LOCK_BITS-1:0] lock_inc, lock_new;
	logic signed [B_W-1:0] dsum;
	logic [WIN_W-1:0]     nsel;
	logic [PP_W:0]        sum_lo, sum_all;
	logic [NUM_W-1:0]     num_abs;
	logic [REM_W:0]       rem_sh, dvs;
	logic                 ge;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]    diff_abs;
	logic [LOCK_BITS+OUT_LOCK_W-1:0] lock_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WIN_RESET;
			interval_q <= INT_RESET;
			thr_q      <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW:   window_q <= cfg_data[WIN_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[INT_W-1:0];
				CFG_JUMP:     thr_q <= cfg_data[THR_W-1:0];
				default:      ;
			endcase
		end
	end

	// Epoch bookkeeping and the clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= '0;
			prev_ne_q <= 1'b0;
			cur_ne_q  <= 1'b0;
			clr_q     <= '0;
			done      <= 1'b0;
		end else begin
			done <= cmd.write;
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept) begin
				cur_ne_q <= 1'b1;
				if (epoch_start) begin
					prev_ne_q <= cur_ne_q;
					epoch_q   <= epoch_q + 1'b1;
				end
			end
		end
	end

	assign sts.clear_done = (clr_q == SLOT_AW'(SLOT_COUNT - 1));

	assign rd       = slot_word_t'(ram_rdata);
	assign present  = rd.valid && (rd.tag == epoch_q - 1'b1);
	assign lock_inc = (&rd.lock) ? rd.lock : rd.lock + 1'b1;

	always_comb begin
		if (!inr_q) begin
			lock_new = '0;
		end else if (!prev_ne_q) begin
			lock_new = LOCK_BITS'(1);
		end else if (p_q != '0) begin
			lock_new = present ? lock_inc : LOCK_BITS'(1);
		end else begin
			lock_new = '0;
		end
	end

	assign sts.smooth = inr_q && prev_ne_q && (p_q != '0) && present && (rd.rng != '0)
		&& (rd.dop != '0) && (draw_q != '0);
	assign dsum = $signed({rd.dop[DOP_W-1], rd.dop}) + $signed({draw_q[DOP_W-1], draw_q});

	always_comb begin
		if ((LOCK_BITS + WIN_W)'(lock_new) < (LOCK_BITS + WIN_W)'(window_q)) begin
			nsel = WIN_W'(lock_new);
		end else begin
			nsel = window_q;
		end
		if (nsel == '0) begin
			nsel = WIN_W'(1);
		end
	end

	assign sum_lo  = (PP_W + 1)'(plo_q) + ((PP_W + 1)'(1) << 38);
	assign sum_all = (PP_W + 1)'(phi_q) + (sum_lo >> 24);
	assign num_abs = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign dvs     = {1'b0, n_q, 1'b0};
	assign ge      = (rem_sh >= dvs);
	assign diff    = DIFF_W'(s_q) - $signed({{(DIFF_W - RANGE_W){1'b0}}, p_q});
	assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign sts.div_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q    <= pseudorange;
			draw_q <= doppler;
			lam_q  <= wavelength;
			inr_q  <= (32'(sat_index) < NUM_SATS) && (32'(freq_slot) < NUM_SLOTS);
			idx_q  <= SLOT_AW'(32'(sat_index) * NUM_SLOTS + 32'(freq_slot));
		end
		if (cmd.read) begin
			tl_q <= TL_W'(interval_q) * TL_W'(lam_q);
		end
		if (cmd.eval) begin
			lock_q     <= lock_new;
			n_q        <= nsel;
			b_q        <= dsum[B_W-1] ? B_W'(-dsum) : B_W'(dsum);
			neg_q      <= dsum[B_W-1];
			prev_rng_q <= rd.rng;
			res_rng_q  <= p_q;
			res_sm_q   <= 1'b0;
		end
		if (cmd.mul_lo) begin
			plo_q <= PP_W'(tl_q[HALF_W-1:0]) * PP_W'(b_q);
		end
		if (cmd.mul_hi) begin
			phi_q <= PP_W'(tl_q[TL_W-1:HALF_W]) * PP_W'(b_q);
		end
		if (cmd.mag) begin
			mag_q <= MAG_W'(sum_all >> 15);
		end
		if (cmd.base) begin
			// The predicted delta opposes the sign of the Doppler sum.
			if (neg_q) begin
				base_q <= $signed(BASE_W'(prev_rng_q)) + $signed(BASE_W'(mag_q));
			end else begin
				base_q <= $signed(BASE_W'(prev_rng_q)) - $signed(BASE_W'(mag_q));
			end
		end
		if (cmd.prod) begin
			prodn_q <= $signed({1'b0, n_q - 1'b1}) * base_q;
		end
		if (cmd.num) begin
			num_q <= $signed(NUM_W'(p_q)) + NUM_W'(prodn_q);
		end
		if (cmd.div_load) begin
			dvd_q  <= {num_abs, 1'b0} + DVD_W'(n_q);
			rem_q  <= '0;
			cnt_q  <= CNT_W'(DVD_W - 1);
			sign_q <= num_q[NUM_W-1];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? REM_W'(rem_sh - dvs) : rem_sh[REM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.sign) begin
			s_q <= sign_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		end
		if (cmd.check) begin
			if (diff_abs < DIFF_W'(thr_q)) begin
				res_sm_q <= 1'b1;
				if (s_q < 0) begin
					res_rng_q <= '0;
				end else if (s_q > $signed(QS_W'({RANGE_W{1'b1}}))) begin
					res_rng_q <= '1;
				end else begin
					res_rng_q <= s_q[RANGE_W-1:0];
				end
			end
		end
		if (cmd.write) begin
			range_out    <= res_rng_q;
			was_smoothed <= res_sm_q;
			lock_count   <= (lock_ext > (LOCK_BITS + OUT_LOCK_W)'({OUT_LOCK_W{1'b1}}))
				? {OUT_LOCK_W{1'b1}} : lock_ext[OUT_LOCK_W-1:0];
		end
	end

	assign lock_ext = (LOCK_BITS + OUT_LOCK_W)'(lock_q);

	always_comb begin
		wr.valid = 1'b1;
		wr.tag   = epoch_q;
		wr.lock  = lock_q;
		wr.dop   = draw_q;
		wr.rng   = res_rng_q;
	end

	assign ram_we    = cmd.clear || (cmd.write && inr_q);
	assign ram_waddr = cmd.clear ? clr_q : idx_q;
	assign ram_wdata = cmd.clear ? '0 : SLOT_W'(wr);
	assign ram_re    = cmd.read;
	assign ram_raddr = idx_q;
endmodule

### rtl/doppler_aided_range_smoother_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     start / busy               epoch_start sat_index freq_slot pseudorange
//                                      doppler wavelength
// result    done (one-cycle strobe)    range_out lock_count was_smoothed
// config    cfg_we                     cfg_index cfg_data
//
// An item is taken when start is high and busy is low, one item at a time.
// An unsmoothed item passes the read, eval and write states; a smoothed one also
// passes multiply, magnitude, base, product, numerator, the 52-step serial divider,
// sign and check. After reset a clearing pass sweeps all 1024 slots with busy held.
// The result is shown for one cycle under done and cannot be held off.
`include "doppler_aided_range_smoother_core_assert.svh"
module doppler_aided_range_smoother_core import dars_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    epoch_start,
	input  logic [SAT_W-1:0]        sat_index,
	input  logic [FS_W-1:0]         freq_slot,
	input  logic [RANGE_W-1:0]      pseudorange,
	input  logic signed [DOP_W-1:0] doppler,
	input  logic [LAM_W-1:0]        wavelength,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    done,
	output logic [RANGE_W-1:0]      range_out,
	output logic [OUT_LOCK_W-1:0]   lock_count,
	output logic                    was_smoothed
);
	// The controller sequences each item through the datapath; the datapath holds
	// all data registers and drives the slot memory port.
	cmd_t cmd;
	sts_t sts;

	logic               ram_we, ram_re;
	logic [SLOT_AW-1:0] ram_waddr, ram_raddr;
	logic [SLOT_W-1:0]  ram_wdata, ram_rdata;

	dars_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dars_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.epoch_start  (epoch_start),
		.sat_index    (sat_index),
		.freq_slot    (freq_slot),
		.pseudorange  (pseudorange),
		.doppler      (doppler),
		.wavelength   (wavelength),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.range_out    (range_out),
		.lock_count   (lock_count),
		.was_smoothed (was_smoothed),
		.done         (done)
	);

	// One word per slot holds range, Doppler, lock count, epoch tag and valid.
	dars_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A result appears only once the controller is back to waiting for an item.
	`DARS_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)
	// A taken item always occupies the block in the following cycle.
	`DARS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// Smoothing needs a slot that was tracked, so its lock count is at least two.
	`DARS_ASSERT_IMP(a_smooth_lock, clk, arst_n, done && was_smoothed, lock_count > 16'd1)
endmodule
